// File: sv/apsp_pkg.sv
// shared types, constants and helpers for the all-pairs shortest path block
// no dependencies; imported by apsp_relax, apsp_seq and the top level
`default_nettype none

package apsp_pkg;

    // store geometry
    localparam int MaxVertices = 16;
    localparam int VtxW        = $clog2(MaxVertices);
    localparam int StoreDepth  = MaxVertices * MaxVertices;
    localparam int AddrW       = $clog2(StoreDepth);
    localparam int CntW        = $clog2(MaxVertices + 1);

    // field widths fixed by the interface
    localparam int DistW  = 16;
    localparam int FieldW = 4;
    localparam int CfgW   = 5;

    localparam logic [DistW-1:0] NoEdge   = 16'hFFFF;
    localparam logic [CfgW-1:0]  VcReset  = 5'd16;

    // command codes
    localparam logic [1:0] CmdClear = 2'd0;
    localparam logic [1:0] CmdEdge  = 2'd1;
    localparam logic [1:0] CmdRun   = 2'd2;
    localparam logic [1:0] CmdQuery = 2'd3;

    typedef struct packed {
        logic [1:0]        command;
        logic [FieldW-1:0] row;
        logic [FieldW-1:0] col;
        logic [DistW-1:0]  weight;
    } cmd_beat_t;

    typedef struct packed {
        logic [DistW-1:0]  distance;
        logic [FieldW-1:0] next_hop;
        logic              reachable;
    } rsp_beat_t;

    // sequencer to datapath: memory ports and pipeline strobes
    typedef struct packed {
        logic [AddrW-1:0] dist_ra;
        logic [AddrW-1:0] dist_rb;
        logic [AddrW-1:0] nh_ra;
        logic             dist_we;
        logic [AddrW-1:0] dist_wa;
        logic [DistW-1:0] dist_wd;
        logic             nh_we;
        logic [AddrW-1:0] nh_wa;
        logic [VtxW-1:0]  nh_wd;
        logic             row_capture;
        logic             relax_issue;
        logic             q_capture;
        logic             q_inside;
        logic             q_load;
    } seq_ctl_t;

    function automatic logic [AddrW-1:0] vtx_addr(input logic [VtxW-1:0] r,
                                                  input logic [VtxW-1:0] c);
        return AddrW'(r) * AddrW'(MaxVertices) + AddrW'(c);
    endfunction

    function automatic logic [VtxW-1:0] to_vtx(input logic [FieldW-1:0] f);
        return VtxW'(f);
    endfunction

    function automatic logic in_store(input logic [FieldW-1:0] f);
        return int'(f) < MaxVertices;
    endfunction

endpackage

`default_nettype wire

// File: sv/apsp_ram.sv
// generic single-write, dual-read synchronous ram with registered read data
// no dependencies; read-first on a same-address write
`default_nettype none

module apsp_ram #(
    parameter int Width = 16,
    parameter int Depth = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] wa,
    input  wire logic [Width-1:0]         wd,
    input  wire logic [$clog2(Depth)-1:0] ra_a,
    input  wire logic [$clog2(Depth)-1:0] ra_b,
    output logic      [Width-1:0]         rd_a,
    output logic      [Width-1:0]         rd_b
);

    logic [Width-1:0] mem_reg [Depth];
    logic [Width-1:0] rd_a_reg;
    logic [Width-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wa] <= wd;
        end
        rd_a_reg <= mem_reg[ra_a];
        rd_b_reg <= mem_reg[ra_b];
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

`default_nettype wire

// File: sv/apsp_relax.sv
// relaxation test of one pair through the current intermediate vertex
// depends on apsp_pkg
`default_nettype none

module apsp_relax import apsp_pkg::*; (
    input  wire logic [DistW-1:0] dist_ik,
    input  wire logic [DistW-1:0] dist_kj,
    input  wire logic [DistW-1:0] dist_ij,
    output logic                  take,
    output logic      [DistW-1:0] sum
);

    logic [DistW:0] sum_wide;

    // strictly shorter, and never reaching the no-edge value
    assign sum_wide = {1'b0, dist_ik} + {1'b0, dist_kj};
    assign take     = (sum_wide < {1'b0, NoEdge}) && (sum_wide < {1'b0, dist_ij});
    assign sum      = sum_wide[DistW-1:0];

endmodule

`default_nettype wire

// File: sv/apsp_seq.sv
// command sequencer: init pass, clear, edge writes, run loops and query steps
// depends on apsp_pkg; drives the memory ports through a seq_ctl_t
`default_nettype none

module apsp_seq import apsp_pkg::*; (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [CfgW-1:0] cfg_data,
    input  wire logic            cmd_valid,
    output logic                 cmd_ready,
    input  wire cmd_beat_t       cmd,
    input  wire logic            out_free,
    output seq_ctl_t             ctl
);

    localparam logic [3:0] StInit   = 4'd0;
    localparam logic [3:0] StIdle   = 4'd1;
    localparam logic [3:0] StClear  = 4'd2;
    localparam logic [3:0] StEdge2  = 4'd3;
    localparam logic [3:0] StNhInit = 4'd4;
    localparam logic [3:0] StRow    = 4'd5;
    localparam logic [3:0] StStream = 4'd6;
    localparam logic [3:0] StDrain  = 4'd7;
    localparam logic [3:0] StQRead  = 4'd8;
    localparam logic [3:0] StQOut   = 4'd9;

    logic [3:0]       state_reg, state_next;
    logic [VtxW-1:0]  i_reg, i_next;
    logic [VtxW-1:0]  j_reg, j_next;
    logic [VtxW-1:0]  k_reg, k_next;
    logic [CntW-1:0]  n_reg, n_next;
    logic [CfgW-1:0]  vc_reg;
    logic [AddrW-1:0] e_addr_reg, e_addr_next;
    logic [DistW-1:0] w_reg, w_next;
    logic             q_inside_reg, q_inside_next;

    logic             accept;
    logic             pair_ok;
    logic [CntW-1:0]  n_sat;
    logic             i_last_all, j_last_all;
    logic             i_last_n, j_last_n, k_last_n;

    assign accept  = cmd_valid && cmd_ready;
    assign pair_ok = in_store(cmd.row) && in_store(cmd.col);
    assign n_sat   = (int'(vc_reg) > MaxVertices) ? CntW'(MaxVertices) : CntW'(vc_reg);

    assign i_last_all = (i_reg == VtxW'(MaxVertices - 1));
    assign j_last_all = (j_reg == VtxW'(MaxVertices - 1));
    assign i_last_n   = (CntW'(i_reg) == n_reg - CntW'(1));
    assign j_last_n   = (CntW'(j_reg) == n_reg - CntW'(1));
    assign k_last_n   = (CntW'(k_reg) == n_reg - CntW'(1));

    assign cmd_ready = (state_reg == StIdle);

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        n_next        = n_reg;
        e_addr_next   = e_addr_reg;
        w_next        = w_reg;
        q_inside_next = q_inside_reg;
        ctl           = '0;
        ctl.q_inside  = q_inside_reg;

        unique case (state_reg)
            StInit, StClear:
            begin
                // full sweep: diagonal 0, no edge elsewhere; init also resets next hops
                ctl.dist_we = 1'b1;
                ctl.dist_wa = vtx_addr(i_reg, j_reg);
                ctl.dist_wd = (i_reg == j_reg) ? '0 : NoEdge;
                ctl.nh_we   = (state_reg == StInit);
                ctl.nh_wa   = vtx_addr(i_reg, j_reg);
                ctl.nh_wd   = j_reg;
                j_next      = j_reg + VtxW'(1);
                if (j_last_all)
                begin
                    j_next = '0;
                    i_next = i_reg + VtxW'(1);
                    if (i_last_all)
                    begin
                        i_next     = '0;
                        state_next = StIdle;
                    end
                end
            end
            StIdle:
            begin
                ctl.dist_ra = vtx_addr(to_vtx(cmd.row), to_vtx(cmd.col));
                ctl.nh_ra   = vtx_addr(to_vtx(cmd.row), to_vtx(cmd.col));
                if (accept)
                begin
                    unique case (cmd.command)
                        CmdClear:
                        begin
                            i_next     = '0;
                            j_next     = '0;
                            state_next = StClear;
                        end
                        CmdEdge:
                        begin
                            if (pair_ok)
                            begin
                                ctl.dist_we = 1'b1;
                                ctl.dist_wa = vtx_addr(to_vtx(cmd.row), to_vtx(cmd.col));
                                ctl.dist_wd = cmd.weight;
                                e_addr_next = vtx_addr(to_vtx(cmd.col), to_vtx(cmd.row));
                                w_next      = cmd.weight;
                                state_next  = StEdge2;
                            end
                        end
                        CmdRun:
                        begin
                            if (n_sat != '0)
                            begin
                                n_next     = n_sat;
                                i_next     = '0;
                                j_next     = '0;
                                k_next     = '0;
                                state_next = StNhInit;
                            end
                        end
                        CmdQuery:
                        begin
                            q_inside_next = pair_ok;
                            state_next    = StQRead;
                        end
                        default:
                        begin
                            state_next = StIdle;
                        end
                    endcase
                end
            end
            StEdge2:
            begin
                ctl.dist_we = 1'b1;
                ctl.dist_wa = e_addr_reg;
                ctl.dist_wd = w_reg;
                state_next  = StIdle;
            end
            StNhInit:
            begin
                ctl.nh_we = 1'b1;
                ctl.nh_wa = vtx_addr(i_reg, j_reg);
                ctl.nh_wd = j_reg;
                j_next    = j_reg + VtxW'(1);
                if (j_last_n)
                begin
                    j_next = '0;
                    i_next = i_reg + VtxW'(1);
                    if (i_last_n)
                    begin
                        i_next     = '0;
                        state_next = StRow;
                    end
                end
            end
            StRow:
            begin
                // fetch d[i][k] and next hop [i][k] for the whole row
                ctl.dist_ra = vtx_addr(i_reg, k_reg);
                ctl.nh_ra   = vtx_addr(i_reg, k_reg);
                state_next  = StStream;
            end
            StStream:
            begin
                ctl.row_capture = (j_reg == '0);
                ctl.relax_issue = 1'b1;
                ctl.dist_ra     = vtx_addr(i_reg, j_reg);
                ctl.dist_rb     = vtx_addr(k_reg, j_reg);
                j_next          = j_reg + VtxW'(1);
                if (j_last_n)
                begin
                    j_next     = '0;
                    i_next     = i_reg + VtxW'(1);
                    state_next = StRow;
                    if (i_last_n)
                    begin
                        i_next = '0;
                        k_next = k_reg + VtxW'(1);
                        if (k_last_n)
                        begin
                            k_next     = '0;
                            state_next = StDrain;
                        end
                    end
                end
            end
            StDrain:
            begin
                state_next = StIdle;
            end
            StQRead:
            begin
                ctl.q_capture = 1'b1;
                state_next    = StQOut;
            end
            StQOut:
            begin
                if (out_free)
                begin
                    ctl.q_load = 1'b1;
                    state_next = StIdle;
                end
            end
            default:
            begin
                state_next = StIdle;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= StInit;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            n_reg        <= '0;
            vc_reg       <= VcReset;
            q_inside_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            n_reg        <= n_next;
            q_inside_reg <= q_inside_next;
            if (cfg_we)
            begin
                vc_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        e_addr_reg <= e_addr_next;
        w_reg      <= w_next;
    end

endmodule

`default_nettype wire

// File: sv/all_pairs_shortest_path.sv
// top level of the all-pairs shortest path block: memories, relax stage, response register
// depends on apsp_pkg, apsp_ram, apsp_relax and apsp_seq
`default_nettype none

// Floyd-Warshall shortest paths over a MaxVertices x MaxVertices distance store and
// next-hop store, both held in synchronous rams. A command beat is clear, set edge,
// run or query; only a query returns a response beat. After reset the block writes
// the reset pattern into both stores, with cmd_ready low. Clear rewrites the distance
// store one entry per cycle, set edge writes both directions in turn (one distance
// write port), and query reads the stores into the response register, then waits
// for the consumer. Run with n = min(vertex_count, MaxVertices) resets the next hops,
// then for each of the n^2 rows fetches d[i][k] and streams one pair per cycle
// through the dual-read distance ram, then drains. vertex_count is written through
// cfg_we/cfg_data and is sampled when a run beat is accepted.
module all_pairs_shortest_path import apsp_pkg::*; (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_we,
    input  wire logic [CfgW-1:0] cfg_data,
    input  wire logic            cmd_valid,
    output logic                 cmd_ready,
    input  wire cmd_beat_t       cmd,
    output logic                 rsp_valid,
    input  wire logic            rsp_ready,
    output rsp_beat_t            rsp
);

    seq_ctl_t         ctl;
    logic             out_free;

    // memory ports
    logic             dist_we;
    logic [AddrW-1:0] dist_wa;
    logic [DistW-1:0] dist_wd;
    logic [DistW-1:0] dist_rd_a;
    logic [DistW-1:0] dist_rd_b;
    logic             nh_we;
    logic [AddrW-1:0] nh_wa;
    logic [VtxW-1:0]  nh_wd;
    logic [VtxW-1:0]  nh_rd;

    // relax stage: one pair per cycle, read data arrives in the cycle after issue
    logic             s_valid_reg;
    logic [AddrW-1:0] s_addr_reg;
    logic [DistW-1:0] dik_reg;
    logic [VtxW-1:0]  nhik_reg;
    logic             take;
    logic [DistW-1:0] sum;
    logic             relax_we;

    // response path
    rsp_beat_t        hold_reg;
    rsp_beat_t        rsp_reg;
    logic             rsp_valid_reg;

    apsp_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready),
        .cmd      (cmd),
        .out_free (out_free),
        .ctl      (ctl)
    );

    apsp_ram #(
        .Width(DistW),
        .Depth(StoreDepth)
    ) u_dist_ram (
        .clk (clk),
        .we  (dist_we),
        .wa  (dist_wa),
        .wd  (dist_wd),
        .ra_a(ctl.dist_ra),
        .ra_b(ctl.dist_rb),
        .rd_a(dist_rd_a),
        .rd_b(dist_rd_b)
    );

    // second read port of the next-hop ram is not needed
    apsp_ram #(
        .Width(VtxW),
        .Depth(StoreDepth)
    ) u_nh_ram (
        .clk (clk),
        .we  (nh_we),
        .wa  (nh_wa),
        .wd  (nh_wd),
        .ra_a(ctl.nh_ra),
        .ra_b(ctl.nh_ra),
        .rd_a(nh_rd),
        .rd_b()
    );

    // port a carries d[i][j], port b carries d[k][j]
    apsp_relax u_relax (
        .dist_ik(dik_reg),
        .dist_kj(dist_rd_b),
        .dist_ij(dist_rd_a),
        .take   (take),
        .sum    (sum)
    );

    assign relax_we = s_valid_reg && take;

    // relax writes and sequencer writes never overlap: relax only runs during a run
    assign dist_we = relax_we || ctl.dist_we;
    assign dist_wa = relax_we ? s_addr_reg : ctl.dist_wa;
    assign dist_wd = relax_we ? sum        : ctl.dist_wd;
    assign nh_we   = relax_we || ctl.nh_we;
    assign nh_wa   = relax_we ? s_addr_reg : ctl.nh_wa;
    assign nh_wd   = relax_we ? nhik_reg   : ctl.nh_wd;

    assign out_free = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s_valid_reg <= ctl.relax_issue;
            if (ctl.q_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s_addr_reg <= ctl.dist_ra;
        // row operands stay fixed while the row streams through
        if (ctl.row_capture)
        begin
            dik_reg  <= dist_rd_a;
            nhik_reg <= nh_rd;
        end
        // query data is back in the cycle after the read
        if (ctl.q_capture)
        begin
            if (ctl.q_inside)
            begin
                hold_reg.distance  <= dist_rd_a;
                hold_reg.next_hop  <= FieldW'(nh_rd);
                hold_reg.reachable <= (dist_rd_a != NoEdge);
            end
            else
            begin
                hold_reg.distance  <= NoEdge;
                hold_reg.next_hop  <= '0;
                hold_reg.reachable <= 1'b0;
            end
        end
        if (ctl.q_load)
        begin
            rsp_reg <= hold_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // sequencer and relax stage must never fight over the write ports
    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(relax_we && (ctl.dist_we || ctl.nh_we)))
        else $error("relax write collides with sequencer write");

    // no command is taken while a relaxation is still in flight
    a_idle_after_relax: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg |-> !cmd_ready)
        else $error("command accepted with relax stage busy");

    // a response is loaded only into a free slot
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.q_load |-> out_free)
        else $error("response overwritten before it was taken");

    // reachable agrees with the distance of the same beat
    a_reach_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_reg.reachable == (rsp_reg.distance != NoEdge)))
        else $error("reachable flag does not match distance");

endmodule

`default_nettype wire
